[rtl/core/assert_macros.svh]
// Assertion macros for the RTL that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define FPP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fpp assertion failed");

// Next-cycle implication, held off while reset is asserted
`define FPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fpp assertion failed");

`endif

[rtl/core/fpp_pkg.sv]
// Shared types, codes and constants of the frame parser
package fpp_pkg;

    localparam int KEPT_BYTES = 14;
    localparam int KEPT_IW    = (KEPT_BYTES > 1) ? $clog2(KEPT_BYTES) : 1;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_SEED  = 2'd2;

    localparam logic [7:0] START_RST = 8'h02;
    localparam logic [7:0] END_RST   = 8'h03;
    localparam logic [7:0] SEED_RST  = 8'h55;

    localparam logic [7:0] ADC_KIND    = 8'h02;
    localparam logic [7:0] ADC_MIN_LEN = 8'd14;

    // frame status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OTHER = 3'd1;
    localparam logic [2:0] ST_CSUM  = 3'd2;
    localparam logic [2:0] ST_NOEND = 3'd3;
    localparam logic [2:0] ST_SHORT = 3'd4;

    typedef logic [KEPT_BYTES-1:0][7:0] t_kept;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] checksum_seed;
    } t_cfg;

    // frame finished: raw status before type classification
    typedef struct packed {
        logic       fire;
        logic [2:0] status;
    } t_event;

    typedef struct packed {
        logic [2:0]         frame_status;
        logic [7:0]         payload_length;
        logic [7:0]         node_address;
        logic [7:0]         packet_kind;
        logic [15:0]        current_reading;
        logic [15:0]        voltage_reading;
        logic [7:0]         phase_byte;
        logic [7:0]         pwm_byte;
        logic signed [15:0] phase_a_reading;
        logic signed [15:0] phase_b_reading;
        logic [15:0]        phase_angle;
    } t_result;

endpackage

[rtl/core/fpp_channels.sv]
// Valid/ready channel interfaces for received bytes and frame results

interface fpp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpp_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         frame_status;
    logic [7:0]         payload_length;
    logic [7:0]         node_address;
    logic [7:0]         packet_kind;
    logic [15:0]        current_reading;
    logic [15:0]        voltage_reading;
    logic [7:0]         phase_byte;
    logic [7:0]         pwm_byte;
    logic signed [15:0] phase_a_reading;
    logic signed [15:0] phase_b_reading;
    logic [15:0]        phase_angle;

    modport source (
        output valid, input ready,
        output frame_status, payload_length, node_address, packet_kind,
        output current_reading, voltage_reading, phase_byte, pwm_byte,
        output phase_a_reading, phase_b_reading, phase_angle
    );
    modport sink (
        input valid, output ready,
        input frame_status, payload_length, node_address, packet_kind,
        input current_reading, voltage_reading, phase_byte, pwm_byte,
        input phase_a_reading, phase_b_reading, phase_angle
    );
endinterface

[rtl/core/fpp_cfg_regs.sv]
// APB-style configuration registers of the frame parser
module fpp_cfg_regs
    import fpp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= START_RST;
            r_cfg.end_byte      <= END_RST;
            r_cfg.checksum_seed <= SEED_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_START: r_cfg.start_byte    <= pwdata[7:0];
                REG_END:   r_cfg.end_byte      <= pwdata[7:0];
                REG_SEED:  r_cfg.checksum_seed <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START: prdata = {24'd0, r_cfg.start_byte};
            REG_END:   prdata = {24'd0, r_cfg.end_byte};
            REG_SEED:  prdata = {24'd0, r_cfg.checksum_seed};
            default:   prdata = '0;
        endcase
    end

endmodule

[rtl/core/fpp_frame_fsm.sv]
// Frame parse state machine: phase, length, count, checksum and kept bytes
module fpp_frame_fsm
    import fpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_event     o_event,
    output logic [7:0] o_length,
    output t_kept      o_kept
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_CSUM_LO = 3'd3;
    localparam logic [2:0] PH_CSUM_HI = 3'd4;
    localparam logic [2:0] PH_END     = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_len,   n_len;
    logic [7:0]  r_cnt,   n_cnt;
    logic [15:0] r_sum,   n_sum;
    t_kept       r_kept;
    logic        kept_wr;
    logic        is_start;

    assign is_start = (i_byte == i_cfg.start_byte);

    always_comb begin
        n_phase         = r_phase;
        n_len           = r_len;
        n_cnt           = r_cnt;
        n_sum           = r_sum;
        kept_wr         = 1'b0;
        o_event.fire    = 1'b0;
        o_event.status  = ST_OTHER;
        unique case (r_phase)
            PH_LEN: begin
                n_len   = i_byte;
                n_cnt   = '0;
                n_sum   = {8'd0, i_cfg.checksum_seed} + {8'd0, i_byte};
                n_phase = (i_byte == 8'd0) ? PH_CSUM_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum   = r_sum + {8'd0, i_byte};
                kept_wr = (r_cnt < 8'(KEPT_BYTES));
                n_cnt   = (r_cnt == 8'hff) ? r_cnt : r_cnt + 8'd1;
                if (n_cnt >= r_len) begin
                    n_phase = PH_CSUM_LO;
                end
            end
            PH_CSUM_LO: begin
                if (r_sum[7:0] != i_byte) begin
                    o_event.fire   = 1'b1;
                    o_event.status = ST_CSUM;
                    n_phase        = is_start ? PH_LEN : PH_IDLE;
                end else begin
                    n_phase = PH_CSUM_HI;
                end
            end
            PH_CSUM_HI: begin
                if (r_sum[15:8] != i_byte) begin
                    o_event.fire   = 1'b1;
                    o_event.status = ST_CSUM;
                    n_phase        = is_start ? PH_LEN : PH_IDLE;
                end else begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                o_event.fire   = 1'b1;
                o_event.status = (i_byte == i_cfg.end_byte) ? ST_OTHER : ST_NOEND;
                n_phase        = PH_IDLE;
            end
            default: begin
                // idle, and the unused codes behave the same
                n_phase = is_start ? PH_LEN : PH_IDLE;
            end
        endcase
        if (!i_step) begin
            o_event.fire = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
        end
    end

    // kept payload: no reset, entries are only read once written
    always_ff @(posedge i_clk) begin
        if (i_step && kept_wr) begin
            r_kept[r_cnt[KEPT_IW-1:0]] <= i_byte;
        end
    end

    assign o_length = r_len;
    assign o_kept   = r_kept;

endmodule

[rtl/core/fpp_adc_decode.sv]
// Classifies a finished frame and unpacks the ADC packet fields
module fpp_adc_decode
    import fpp_pkg::*;
(
    input  logic [2:0] i_status,
    input  logic [7:0] i_length,
    input  t_kept      i_kept,
    output t_result    o_result
);

    logic [2:0] status;
    logic       has_addr;
    logic       has_kind;

    assign has_addr = (i_length >= 8'd1);
    assign has_kind = (i_length >= 8'd2);

    always_comb begin
        status = i_status;
        if (i_status == ST_OK || i_status == ST_OTHER) begin
            if (has_kind && i_kept[1] == ADC_KIND) begin
                status = (i_length >= ADC_MIN_LEN) ? ST_OK : ST_SHORT;
            end else begin
                status = ST_OTHER;
            end
        end

        o_result                = '0;
        o_result.frame_status   = status;
        o_result.payload_length = i_length;
        o_result.node_address   = has_addr ? i_kept[0] : 8'd0;
        o_result.packet_kind    = has_kind ? i_kept[1] : 8'd0;
        if (status == ST_OK) begin
            o_result.current_reading = {i_kept[3], i_kept[2]};
            o_result.voltage_reading = {i_kept[5], i_kept[4]};
            o_result.phase_byte      = i_kept[6];
            o_result.pwm_byte        = i_kept[7];
            o_result.phase_a_reading = {i_kept[9], i_kept[8]};
            o_result.phase_b_reading = {i_kept[11], i_kept[10]};
            o_result.phase_angle     = {i_kept[13], i_kept[12]};
        end
    end

endmodule

[rtl/core/framed_packet_parser_adc_decode_unit.sv]
// Top level of the framed serial packet parser with ADC decode
//
// Usage notes
// - i_rx carries one received UART byte per transfer (valid/ready).
// - o_res carries one result per finished or failed frame: status, length,
//   address, type and, for a good ADC packet (type 2, 14+ bytes), the
//   decoded little-endian readings. Other statuses leave the readings 0.
// - Frame: start byte, length, payload, checksum low/high, end byte.
//   Checksum = seed + length + payload bytes, 16-bit wrapping.
// - A byte is held in the input register, then the parse state and the
//   result register update together: a result is offered from the result
//   register once the byte that closes the frame leaves the input register.
// - Throughput: one byte per cycle while o_res does not stall (single-pass step).
// - A result waiting on a stalled receiver holds the result register;
//   one more byte is still taken into the input register, then i_rx.ready
//   drops until the result is transferred out.
// - Reset (i_rst_n low, synchronous): parser idle, no result pending,
//   registers back to start 0x02, end 0x03, seed 0x55.
// - Registers: APB, 0x0 start byte, 0x4 end byte, 0x8 checksum seed.
//   Write only while no frame is in progress.
module framed_packet_parser_adc_decode_unit
    import fpp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    fpp_rx_if.sink            i_rx,
    fpp_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_event  evt;
    t_kept   kept;
    t_result res;
    logic [7:0] frame_len;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       step;
    logic       in_ready;

    // terms used by the checks at the end
    logic       res_ok;
    logic       res_not_ok;
    logic       readings_zero;
    logic       out_blocked;

    fpp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the held byte moves on when the result register is free or emptying
    assign step     = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || step;
    assign i_rx.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    fpp_frame_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_event  (evt),
        .o_length (frame_len),
        .o_kept   (kept)
    );

    // length and kept bytes do not change in the phases that end a frame
    fpp_adc_decode u_dec (
        .i_status (evt.status),
        .i_length (frame_len),
        .i_kept   (kept),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && evt.fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && evt.fire) begin
            r_out <= res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.frame_status    = r_out.frame_status;
    assign o_res.payload_length  = r_out.payload_length;
    assign o_res.node_address    = r_out.node_address;
    assign o_res.packet_kind     = r_out.packet_kind;
    assign o_res.current_reading = r_out.current_reading;
    assign o_res.voltage_reading = r_out.voltage_reading;
    assign o_res.phase_byte      = r_out.phase_byte;
    assign o_res.pwm_byte        = r_out.pwm_byte;
    assign o_res.phase_a_reading = r_out.phase_a_reading;
    assign o_res.phase_b_reading = r_out.phase_b_reading;
    assign o_res.phase_angle     = r_out.phase_angle;

    assign res_ok        = r_out_valid && (r_out.frame_status == ST_OK);
    assign res_not_ok    = r_out_valid && (r_out.frame_status != ST_OK);
    assign readings_zero = (r_out.current_reading == 16'd0)
                           && (r_out.voltage_reading == 16'd0)
                           && (r_out.phase_angle == 16'd0);
    assign out_blocked   = r_in_valid && r_out_valid && !o_res.ready;

    `include "assert_macros.svh"

    // a good ADC result always comes from a long enough frame
    `FPP_ASSERT_SAME(a_ok_len, i_clk, i_rst_n, res_ok, r_out.payload_length >= ADC_MIN_LEN)

    // current, voltage and phase angle readings are cleared on every result that is not a good ADC packet
    `FPP_ASSERT_SAME(a_zero_fields, i_clk, i_rst_n, res_not_ok, readings_zero)

    // input side only stalls behind a held byte and a blocked result
    `FPP_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !in_ready, out_blocked)

    // a frame event while stepping always lands in the result register
    `FPP_ASSERT_NEXT(a_event_out, i_clk, i_rst_n, step && evt.fire, r_out_valid)

endmodule
